// ===== src/pcel_pkg.sv =====
package pcel_pkg;

	// Field widths of the stream transactions
	localparam int KIND_W    = 2;
	localparam int ADDR_W    = 32;
	localparam int SPAN_W    = 32;
	localparam int SLOT_W    = 12;
	localparam int COUNT_W   = 13;
	localparam int STATUS_W  = 3;
	localparam int REGION_W  = 3;
	localparam int INDEX_W   = 12;

	// Request kinds
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd3;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_NO_REGION  = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_NO_EVENT   = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_TABLE_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_FOUND  = 3'd4;

	// Outcome of the shared comparator
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

	// Region table update command
	typedef struct packed {
		logic set;
		logic clr;
	} reg_cmd_t;

endpackage

// ===== src/pcel_cmp.sv =====
module pcel_cmp import pcel_pkg::*; #(
	parameter int W = 33
) (
	input  logic [W-1:0] x,
	input  logic [W-1:0] y,
	output cmp_res_t     res
);

	// Single unsigned magnitude and equality compare, shared by every scan and search step
	assign res.lt = (x < y);
	assign res.eq = (x == y);

endmodule

// ===== src/pcel_regions.sv =====
module pcel_regions import pcel_pkg::*; #(
	parameter int SLOTS = 8,
	parameter int AW    = 32,
	parameter int IW    = 3
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [IW-1:0]      idx,
	input  reg_cmd_t           cmd,
	input  logic [AW-1:0]      wr_start,
	input  logic [AW:0]        wr_end,
	input  logic [SLOT_W-1:0]  wr_first,
	input  logic [COUNT_W-1:0] wr_count,
	output logic               rd_valid_q,
	output logic [AW-1:0]      rd_start_q,
	output logic [AW:0]        rd_end_q,
	output logic [SLOT_W-1:0]  rd_first_q,
	output logic [COUNT_W-1:0] rd_count_q
);

	logic [AW-1:0]      start_mem [SLOTS];
	logic [AW:0]        end_mem   [SLOTS];
	logic [SLOT_W-1:0]  first_mem [SLOTS];
	logic [COUNT_W-1:0] count_mem [SLOTS];
	logic [SLOTS-1:0]   valid_q;

	// Write the entry on add, read the addressed entry every cycle
	always_ff @(posedge clk) begin
		if (cmd.set) begin
			start_mem[idx] <= wr_start;
			end_mem[idx]   <= wr_end;
			first_mem[idx] <= wr_first;
			count_mem[idx] <= wr_count;
		end
		rd_start_q <= start_mem[idx];
		rd_end_q   <= end_mem[idx];
		rd_first_q <= first_mem[idx];
		rd_count_q <= count_mem[idx];
	end

	// Hold the valid flags; set on add, drop on remove
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.set) begin
				valid_q[idx] <= 1'b1;
			end else if (cmd.clr) begin
				valid_q[idx] <= 1'b0;
			end
			rd_valid_q <= valid_q[idx];
		end
	end

endmodule

// ===== src/pcel_event_mem.sv =====
module pcel_event_mem #(
	parameter int DEPTH = 4096,
	parameter int AW    = 32,
	parameter int IW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [IW-1:0] raddr,
	output logic [AW-1:0] rdata_q
);

	logic [AW-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ===== src/pc_event_lookup.sv =====
// Sequence: a load writes the event memory and goes straight to its result; add, remove
// and lookup scan the region table slot by slot, then a lookup runs a binary search over
// the region's events, paced by the single event memory read port and the one shared
// comparator.
// Throughput: one transaction at a time; s_axis_tready is high only between requests.
// Reset: arst_n clears the sequencer, output valid and region valid flags; memories hold.
module pc_event_lookup import pcel_pkg::*; #(
	parameter int REGION_SLOTS = 8,
	parameter int EVENT_DEPTH  = 4096, // power of two
	parameter int ADDRESS_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// address [31:0], span [63:32], slot [75:64], count [88:76], zero [95:89]
	input  logic [95:0] s_axis_tdata,
	// kind [1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// region [2:0], event_index [14:3], exact [15]
	output logic [15:0] m_axis_tdata,
	// status [2:0]
	output logic [2:0]  m_axis_tuser
);

	localparam int AW  = ADDRESS_BITS;
	localparam int EIW = $clog2(EVENT_DEPTH);
	localparam int NW  = EIW + 1;
	localparam int CW  = (COUNT_W > NW) ? COUNT_W : NW;
	localparam int RIW = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_R_RD   = 4'd1;
	localparam logic [3:0] ST_R_CHK  = 4'd2;
	localparam logic [3:0] ST_R_END  = 4'd3;
	localparam logic [3:0] ST_S_INIT = 4'd4;
	localparam logic [3:0] ST_S_LOOP = 4'd5;
	localparam logic [3:0] ST_S_CMP  = 4'd6;
	localparam logic [3:0] ST_F_EQ   = 4'd7;
	localparam logic [3:0] ST_F_NXT  = 4'd8;
	localparam logic [3:0] ST_G_EQ   = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       m_valid_q;

	logic [KIND_W-1:0]  kind_q;
	logic [AW-1:0]      a_q;
	logic [AW:0]        a1_q;
	logic [AW:0]        end_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [COUNT_W-1:0] count_q;
	logic [RIW-1:0]     i_q, i_d;
	logic [EIW-1:0]     first_q;
	logic [NW-1:0]      n_q, lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
	logic [AW-1:0]      v_q;

	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic [RIW-1:0]      res_region_q, res_region_d;
	logic [INDEX_W-1:0]  res_index_q, res_index_d;
	logic                res_exact_q, res_exact_d;
	logic                res_load;
	logic                step_next;

	logic [15:0] out_data_q;
	logic [2:0]  out_user_q;

	logic [KIND_W-1:0]  in_kind;
	logic [AW-1:0]      in_addr;
	logic [AW-1:0]      in_span;
	logic [SLOT_W-1:0]  in_slot;
	logic [COUNT_W-1:0] in_count;
	logic               in_fire;
	logic               out_free;

	logic               rd_valid;
	logic [AW-1:0]      rd_start;
	logic [AW:0]        rd_end;
	logic [SLOT_W-1:0]  rd_first;
	logic [COUNT_W-1:0] rd_count;
	reg_cmd_t           reg_cmd;

	logic [EIW-1:0] ev_raddr;
	logic [AW-1:0]  ev_rdata;
	logic [NW-1:0]  ev_k;

	logic [AW:0]    cmp_x, cmp_y;
	cmp_res_t       cmp;

	logic [NW:0]    mid_sum;
	logic [NW-1:0]  mid_c;
	logic [NW-1:0]  lo_inc;
	logic           more_c;
	logic [CW-1:0]  count_ext;
	logic [NW-1:0]  n_c;
	logic [EIW-1:0] idx_lo, idx_lo1;

	// Unpack the request
	assign in_kind  = s_axis_tuser;
	assign in_addr  = AW'(s_axis_tdata[31:0]);
	assign in_span  = AW'(s_axis_tdata[63:32]);
	assign in_slot  = s_axis_tdata[75:64];
	assign in_count = s_axis_tdata[88:76];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Search arithmetic
	assign mid_sum   = (NW + 1)'(lo_q) + (NW + 1)'(hi_q);
	assign mid_c     = mid_sum[NW:1];
	assign lo_inc    = lo_q + NW'(1);
	assign more_c    = (lo_inc < hi_q);
	assign count_ext = CW'(rd_count);
	assign n_c       = (count_ext > CW'(EVENT_DEPTH)) ? NW'(EVENT_DEPTH) : NW'(count_ext);
	assign idx_lo    = first_q + lo_q[EIW-1:0];
	assign idx_lo1   = first_q + lo_inc[EIW-1:0];

	// Pick the event position to read
	always_comb begin
		if (state_q == ST_S_LOOP && more_c) begin
			ev_k = mid_c;
		end else if (state_q == ST_F_NXT) begin
			ev_k = lo_inc;
		end else begin
			ev_k = lo_q;
		end
	end
	assign ev_raddr = first_q + ev_k[EIW-1:0];

	// Steer the shared comparator
	always_comb begin
		if (state_q == ST_F_NXT || state_q == ST_G_EQ) begin
			cmp_x = a1_q;
		end else begin
			cmp_x = (AW + 1)'(a_q);
		end
		unique case (state_q)
			ST_R_CHK: cmp_y = (AW + 1)'(rd_start);
			ST_R_END: cmp_y = rd_end;
			ST_F_NXT: cmp_y = (AW + 1)'(v_q);
			default:  cmp_y = (AW + 1)'(ev_rdata);
		endcase
	end

	pcel_cmp #(.W(AW + 1)) u_cmp (
		.x   (cmp_x),
		.y   (cmp_y),
		.res (cmp)
	);

	// Region table updates from the scan
	assign reg_cmd.set = (state_q == ST_R_CHK) && (kind_q == KIND_ADD) && !rd_valid;
	assign reg_cmd.clr = (state_q == ST_R_CHK) && (kind_q == KIND_REMOVE) && rd_valid && cmp.eq;

	pcel_regions #(.SLOTS(REGION_SLOTS), .AW(AW), .IW(RIW)) u_regions (
		.clk        (clk),
		.arst_n     (arst_n),
		.idx        (i_q),
		.cmd        (reg_cmd),
		.wr_start   (a_q),
		.wr_end     (end_q),
		.wr_first   (slot_q),
		.wr_count   (count_q),
		.rd_valid_q (rd_valid),
		.rd_start_q (rd_start),
		.rd_end_q   (rd_end),
		.rd_first_q (rd_first),
		.rd_count_q (rd_count)
	);

	pcel_event_mem #(.DEPTH(EVENT_DEPTH), .AW(AW), .IW(EIW)) u_events (
		.clk     (clk),
		.we      (in_fire && (in_kind == KIND_LOAD)),
		.waddr   (EIW'(in_slot)),
		.wdata   (in_addr),
		.raddr   (ev_raddr),
		.rdata_q (ev_rdata)
	);

	// Sequencer
	always_comb begin
		state_d      = state_q;
		i_d          = i_q;
		lo_d         = lo_q;
		hi_d         = hi_q;
		mid_d        = mid_q;
		res_load     = 1'b0;
		res_status_d = STAT_OK;
		res_region_d = '0;
		res_index_d  = '0;
		res_exact_d  = 1'b0;
		step_next    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_kind == KIND_LOAD) begin
						res_load    = 1'b1;
						res_index_d = INDEX_W'(EIW'(in_slot));
						state_d     = ST_DONE;
					end else begin
						i_d     = '0;
						state_d = ST_R_RD;
					end
				end
			end
			ST_R_RD: begin
				state_d = ST_R_CHK;
			end
			ST_R_CHK: begin
				unique case (kind_q)
					KIND_ADD: begin
						if (!rd_valid) begin
							res_load     = 1'b1;
							res_region_d = i_q;
							state_d      = ST_DONE;
						end else begin
							step_next = 1'b1;
						end
					end
					KIND_REMOVE: begin
						if (rd_valid && cmp.eq) begin
							res_load     = 1'b1;
							res_region_d = i_q;
							state_d      = ST_DONE;
						end else begin
							step_next = 1'b1;
						end
					end
					default: begin
						if (rd_valid && !cmp.lt) begin
							state_d = ST_R_END;
						end else begin
							step_next = 1'b1;
						end
					end
				endcase
			end
			ST_R_END: begin
				if (cmp.lt) begin
					state_d = ST_S_INIT;
				end else begin
					step_next = 1'b1;
				end
			end
			ST_S_INIT: begin
				if (n_c == '0) begin
					res_load     = 1'b1;
					res_status_d = STAT_NO_EVENT;
					res_region_d = i_q;
					state_d      = ST_DONE;
				end else begin
					lo_d    = '0;
					hi_d    = n_c;
					state_d = ST_S_LOOP;
				end
			end
			ST_S_LOOP: begin
				if (more_c) begin
					mid_d   = mid_c;
					state_d = ST_S_CMP;
				end else begin
					state_d = ST_F_EQ;
				end
			end
			ST_S_CMP: begin
				if (cmp.lt) begin
					hi_d = mid_q;
				end else begin
					lo_d = mid_q;
				end
				state_d = ST_S_LOOP;
			end
			ST_F_EQ: begin
				if (cmp.eq) begin
					res_load     = 1'b1;
					res_region_d = i_q;
					res_index_d  = INDEX_W'(idx_lo);
					res_exact_d  = 1'b1;
					state_d      = ST_DONE;
				end else begin
					state_d = ST_F_NXT;
				end
			end
			ST_F_NXT: begin
				if (cmp.eq) begin
					res_load     = 1'b1;
					res_region_d = i_q;
					res_index_d  = INDEX_W'(idx_lo);
					state_d      = ST_DONE;
				end else if (lo_inc < n_q) begin
					state_d = ST_G_EQ;
				end else begin
					res_load     = 1'b1;
					res_status_d = STAT_NO_EVENT;
					res_region_d = i_q;
					state_d      = ST_DONE;
				end
			end
			ST_G_EQ: begin
				res_load     = 1'b1;
				res_region_d = i_q;
				state_d      = ST_DONE;
				if (cmp.eq) begin
					res_index_d = INDEX_W'(idx_lo1);
				end else begin
					res_status_d = STAT_NO_EVENT;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Advance the region scan or give up after the last slot
		if (step_next) begin
			if (i_q == RIW'(REGION_SLOTS - 1)) begin
				res_load = 1'b1;
				state_d  = ST_DONE;
				if (kind_q == KIND_ADD) begin
					res_status_d = STAT_TABLE_FULL;
				end else if (kind_q == KIND_REMOVE) begin
					res_status_d = STAT_NOT_FOUND;
				end else begin
					res_status_d = STAT_NO_REGION;
				end
			end else begin
				i_d     = i_q + RIW'(1);
				state_d = ST_R_RD;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_q  <= in_kind;
			a_q     <= in_addr;
			a1_q    <= (AW + 1)'(in_addr) + (AW + 1)'(1);
			end_q   <= (AW + 1)'(in_addr) + (AW + 1)'(in_span);
			slot_q  <= in_slot;
			count_q <= in_count;
		end
		i_q   <= i_d;
		lo_q  <= lo_d;
		hi_q  <= hi_d;
		mid_q <= mid_d;
		if (state_q == ST_S_INIT) begin
			first_q <= EIW'(rd_first);
			n_q     <= n_c;
		end
		if (state_q == ST_F_EQ) begin
			v_q <= ev_rdata;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_region_q <= res_region_d;
			res_index_q  <= res_index_d;
			res_exact_q  <= res_exact_d;
		end
		if (state_q == ST_DONE && out_free) begin
			out_data_q <= {res_exact_q, res_index_q, REGION_W'(res_region_q)};
			out_user_q <= res_status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	// Search window stays open and inside the region
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_S_LOOP) |-> (lo_q < hi_q) && (hi_q <= n_q))
		else $error("search window out of order");

	// A finished result reaches the output and the block returns to idle
	a_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> m_axis_tvalid && s_axis_tready)
		else $error("result not handed to output");

	// Region table changes only during a scan check
	a_table: assert property (@(posedge clk) disable iff (!arst_n)
		(reg_cmd.set || reg_cmd.clr) |-> (state_q == ST_R_CHK) && !(reg_cmd.set && reg_cmd.clr))
		else $error("region table update outside scan");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import pcel_pkg::*;

	localparam int REGIONS    = 8;
	localparam int EVENTS     = 4096;
	localparam int ITEMS      = 450;
	localparam int LIMIT      = 400000;
	localparam int PRINT_MAX  = 60;

	typedef struct {
		logic [KIND_W-1:0]  kind;
		logic [ADDR_W-1:0]  address;
		logic [SPAN_W-1:0]  span;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} request_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [REGION_W-1:0] region;
		logic [INDEX_W-1:0]  index;
		logic                exact;
	} answer_t;

	typedef struct {
		request_t req;
		bit       typed;
		answer_t  want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;

	// Shadow copy of the region table and event memory
	logic                reg_valid [REGIONS];
	logic [ADDR_W-1:0]   reg_start [REGIONS];
	logic [ADDR_W:0]     reg_end   [REGIONS];
	logic [SLOT_W-1:0]   reg_first [REGIONS];
	logic [COUNT_W-1:0]  reg_count [REGIONS];
	logic [ADDR_W-1:0]   ev_mem    [EVENTS];
	bit                  ev_loaded [EVENTS];

	answer_t   answers_due [$];
	plan_row_t plan [$];
	answer_t   head;
	int        mismatches = 0;
	int        items_sent = 0;
	int        burst_left = 0;
	int        cycle_count = 0;
	int        rx_left = 0;
	int        rx_mode = 0;
	logic [3:0] rx_phase = '0;

	pc_event_lookup dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	function automatic request_t mk(input logic [KIND_W-1:0] kind, input logic [31:0] address,
			input logic [31:0] span, input logic [11:0] slot, input logic [12:0] count);
		request_t r;
		r.kind = kind;
		r.address = address;
		r.span = span;
		r.slot = slot;
		r.count = count;
		return r;
	endfunction

	// Number of events a region searches: counts past the memory size are clipped
	function automatic int events_of(input int rg);
		return (reg_count[rg] > COUNT_W'(EVENTS)) ? EVENTS : int'(reg_count[rg]);
	endfunction

	function automatic logic [31:0] ev_at(input logic [11:0] first, input int k);
		logic [11:0] idx;
		idx = first + k[11:0];
		return ev_mem[idx];
	endfunction

	// Lowest valid region holding the address, or -1
	function automatic int region_hit(input logic [31:0] a);
		int hit;
		hit = -1;
		for (int i = REGIONS - 1; i >= 0; i--)
			if (reg_valid[i] && a >= reg_start[i] && {1'b0, a} < reg_end[i])
				hit = i;
		return hit;
	endfunction

	// True when a lookup of this address reads only loaded event entries
	function automatic bit slice_loaded(input logic [31:0] a);
		int hit;
		bit ok;
		logic [11:0] idx;
		hit = region_hit(a);
		ok = 1'b1;
		if (hit >= 0)
			for (int k = 0; k < events_of(hit); k++) begin
				idx = reg_first[hit] + k[11:0];
				if (!ev_loaded[idx])
					ok = 1'b0;
			end
		return ok;
	endfunction

	// Apply one request to the shadow state and work out its answer
	function automatic answer_t resolve_request(input request_t r);
		answer_t ans;
		bit done;
		int hit, n, lo, hi, mid;
		logic [31:0] nxt, v;
		bit has_next;
		ans = '{STAT_OK, '0, '0, 1'b0};
		done = 1'b0;
		case (r.kind)
			KIND_LOAD: begin
				ev_mem[r.slot] = r.address;
				ev_loaded[r.slot] = 1'b1;
				ans.index = r.slot;
			end
			KIND_ADD: begin
				for (int i = 0; i < REGIONS; i++)
					if (!done && !reg_valid[i]) begin
						reg_valid[i] = 1'b1;
						reg_start[i] = r.address;
						reg_end[i] = {1'b0, r.address} + {1'b0, r.span};
						reg_first[i] = r.slot;
						reg_count[i] = r.count;
						ans.region = i[2:0];
						done = 1'b1;
					end
				if (!done)
					ans.status = STAT_TABLE_FULL;
			end
			KIND_REMOVE: begin
				for (int i = 0; i < REGIONS; i++)
					if (!done && reg_valid[i] && reg_start[i] == r.address) begin
						reg_valid[i] = 1'b0;
						ans.region = i[2:0];
						done = 1'b1;
					end
				if (!done)
					ans.status = STAT_NOT_FOUND;
			end
			default: begin
				hit = region_hit(r.address);
				if (hit < 0) begin
					ans.status = STAT_NO_REGION;
				end else begin
					ans.region = hit[2:0];
					ans.status = STAT_NO_EVENT;
					n = events_of(hit);
					has_next = (r.address != '1);
					nxt = r.address + 32'd1;
					if (n > 0) begin
						// Narrow to the last event not above the address
						lo = 0;
						hi = n;
						while (lo + 1 < hi) begin
							mid = (lo + hi) / 2;
							if (r.address < ev_at(reg_first[hit], mid))
								hi = mid;
							else
								lo = mid;
						end
						v = ev_at(reg_first[hit], lo);
						if (v == r.address || (has_next && v == nxt)) begin
							ans.status = STAT_OK;
							ans.index = reg_first[hit] + lo[11:0];
							ans.exact = (v == r.address);
						end else if (lo + 1 < n && has_next &&
								ev_at(reg_first[hit], lo + 1) == nxt) begin
							ans.status = STAT_OK;
							ans.index = reg_first[hit] + lo[11:0] + 12'd1;
						end
					end
				end
			end
		endcase
		return ans;
	endfunction

	task automatic flag(input string what, input logic [31:0] got, input logic [31:0] want);
		if (mismatches < PRINT_MAX)
			$display("mismatch: %s got %0h want %0h at cycle %0d", what, got, want,
				cycle_count);
		mismatches++;
	endtask

	// Present one request, holding it until accepted; optionally idle between bursts
	task automatic issue(input request_t r, input bit typed, input answer_t typed_ans);
		answer_t ans;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, r.count, r.slot, r.span, r.address};
		s_axis_tuser <= r.kind;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ans = resolve_request(r);
		if (typed)
			ans = typed_ans;
		answers_due.push_back(ans);
		items_sent++;
		burst_left--;
	endtask

	// Hold off the sender until every answer is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (answers_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic plan_row(input logic [1:0] kind, input logic [31:0] address,
			input logic [31:0] span, input logic [11:0] slot, input logic [12:0] count,
			input bit typed, input logic [2:0] st, input logic [2:0] rg,
			input logic [11:0] idx, input logic ex);
		plan_row_t p;
		p.req = mk(kind, address, span, slot, count);
		p.typed = typed;
		p.want = '{st, rg, idx, ex};
		plan.push_back(p);
	endtask

	// Receiver: stall in randomly chosen modes, each held for a random stretch
	always @(posedge clk) begin
		rx_phase <= rx_phase + 4'd1;
		if (rx_left == 0) begin
			rx_mode <= $urandom_range(0, 3);
			rx_left <= $urandom_range(20, 120);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= (rx_phase >= 4'd5);
			default: m_axis_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Check each result transaction against the oldest answer due
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				flag("unexpected result, status", m_axis_tuser, '0);
			end else begin
				head = answers_due.pop_front();
				if (m_axis_tuser != head.status)
					flag("status", m_axis_tuser, head.status);
				if (m_axis_tdata[2:0] != head.region)
					flag("region", m_axis_tdata[2:0], head.region);
				if (m_axis_tdata[14:3] != head.index)
					flag("event_index", m_axis_tdata[14:3], head.index);
				if (m_axis_tdata[15] != head.exact)
					flag("exact", m_axis_tdata[15], head.exact);
			end
		end
	end

	initial begin
		int n, first, sel, free_slots, pick;
		logic [31:0] base, cur, span, e, addr, tmp;
		logic [31:0] ev [$];
		bit mid_drained;

		mid_drained = 1'b0;
		foreach (reg_valid[i])
			reg_valid[i] = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: empty table, wrapped slice, top of range, full table
		plan_row(KIND_LOOKUP, 32'h0, 32'h0, 12'h0, 13'h0, 1, STAT_NO_REGION, 0, 0, 0);
		plan_row(KIND_REMOVE, 32'h0, 32'h0, 12'h0, 13'h0, 1, STAT_NOT_FOUND, 0, 0, 0);
		plan_row(KIND_LOAD, 32'h100, 32'h0, 12'hFFE, 13'h0, 1, STAT_OK, 0, 12'hFFE, 0);
		plan_row(KIND_LOAD, 32'h102, 32'h0, 12'hFFF, 13'h0, 1, STAT_OK, 0, 12'hFFF, 0);
		plan_row(KIND_LOAD, 32'h105, 32'h0, 12'h000, 13'h0, 1, STAT_OK, 0, 12'h000, 0);
		plan_row(KIND_LOAD, 32'h108, 32'h0, 12'h001, 13'h0, 1, STAT_OK, 0, 12'h001, 0);
		plan_row(KIND_LOAD, 32'hFFFFFFF8, 32'h0, 12'h002, 13'h0, 1, STAT_OK, 0, 12'h002, 0);
		plan_row(KIND_LOAD, 32'h0, 32'h0, 12'h003, 13'h0, 1, STAT_OK, 0, 12'h003, 0);
		plan_row(KIND_ADD, 32'h100, 32'h10, 12'hFFE, 13'd4, 1, STAT_OK, 0, 0, 0);
		plan_row(KIND_ADD, 32'hFFFFFFF0, 32'hFFFFFFFF, 12'h002, 13'd2, 1, STAT_OK, 1, 0, 0);
		plan_row(KIND_ADD, 32'h200, 32'h4, 12'h000, 13'd0, 1, STAT_OK, 2, 0, 0);
		plan_row(KIND_LOOKUP, 32'h102, 32'h0, 12'h0, 13'h0, 0, 0, 0, 0, 0);
		plan_row(KIND_LOOKUP, 32'h101, 32'h0, 12'h0, 13'h0, 0, 0, 0, 0, 0);
		plan_row(KIND_LOOKUP, 32'h104, 32'h0, 12'h0, 13'h0, 0, 0, 0, 0, 0);
		plan_row(KIND_LOOKUP, 32'h10A, 32'h0, 12'h0, 13'h0, 0, 0, 0, 0, 0);
		plan_row(KIND_LOOKUP, 32'h110, 32'h0, 12'h0, 13'h0, 1, STAT_NO_REGION, 0, 0, 0);
		plan_row(KIND_LOOKUP, 32'hFFFFFFFF, 32'h0, 12'h0, 13'h0, 0, 0, 0, 0, 0);
		plan_row(KIND_LOOKUP, 32'hFFFFFFF8, 32'h0, 12'h0, 13'h0, 0, 0, 0, 0, 0);
		plan_row(KIND_LOOKUP, 32'h201, 32'h0, 12'h0, 13'h0, 1, STAT_NO_EVENT, 2, 0, 0);
		for (int i = 3; i < REGIONS; i++)
			plan_row(KIND_ADD, 32'h1000, 32'h0, 12'hFFF, 13'd4096, 1, STAT_OK, i[2:0], 0, 0);
		plan_row(KIND_ADD, 32'h2000, 32'h10, 12'h0, 13'd1, 1, STAT_TABLE_FULL, 0, 0, 0);
		plan_row(KIND_REMOVE, 32'h1000, 32'h0, 12'h0, 13'h0, 1, STAT_OK, 3, 0, 0);
		plan_row(KIND_REMOVE, 32'h1000, 32'h0, 12'h0, 13'h0, 1, STAT_OK, 4, 0, 0);
		foreach (plan[p])
			issue(plan[p].req, plan[p].typed, plan[p].want);
		drain();

		// Random part: mostly load, add, look up and remove sequences
		while (items_sent < ITEMS) begin
			if (!mid_drained && items_sent >= ITEMS / 2) begin
				drain();
				mid_drained = 1'b1;
			end
			sel = $urandom_range(0, 9);
			if (sel <= 6) begin
				// Make room in a full table
				free_slots = 0;
				foreach (reg_valid[i])
					if (!reg_valid[i])
						free_slots++;
				if (free_slots == 0) begin
					pick = $urandom_range(0, REGIONS - 1);
					issue(mk(KIND_REMOVE, reg_start[pick], $urandom(),
						12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096))),
						0, '{0, 0, 0, 0});
				end
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
				first = $urandom_range(0, EVENTS - 1);
				base = $urandom();
				cur = base + $urandom_range(0, 3);
				ev.delete();
				for (int j = 0; j < n; j++) begin
					ev.push_back(cur);
					cur = cur + $urandom_range(0, 4);
				end
				// Occasionally break the ordering of the slice
				if (n > 1 && $urandom_range(0, 7) == 0) begin
					tmp = ev[0];
					ev[0] = ev[n - 1];
					ev[n - 1] = tmp;
				end
				for (int j = 0; j < n; j++)
					issue(mk(KIND_LOAD, ev[j], $urandom(), 12'(first + j),
						13'($urandom_range(0, 4096))), 0, '{0, 0, 0, 0});
				span = ($urandom_range(0, 15) == 0) ? $urandom() :
					cur - base + $urandom_range(0, 6);
				issue(mk(KIND_ADD, base, span, first[11:0], n[12:0]), 0, '{0, 0, 0, 0});
				repeat ($urandom_range(2, 6)) begin
					e = ev[$urandom_range(0, n - 1)];
					case ($urandom_range(0, 5))
						0: addr = e;
						1: addr = e - 32'd1;
						2: addr = e + 32'd1;
						3: addr = base + $urandom_range(0, cur - base + 4);
						4: addr = $urandom();
						default: addr = e - 32'd2;
					endcase
					if (slice_loaded(addr))
						issue(mk(KIND_LOOKUP, addr, $urandom(),
							12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096))),
							0, '{0, 0, 0, 0});
				end
				if ($urandom_range(0, 1))
					issue(mk(KIND_REMOVE, base, $urandom(),
						12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096))),
						0, '{0, 0, 0, 0});
			end else if (sel == 7) begin
				// Stray lookup or removal of an unknown start
				addr = $urandom();
				if ($urandom_range(0, 1))
					issue(mk(KIND_REMOVE, addr, $urandom(),
						12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096))),
						0, '{0, 0, 0, 0});
				else if (slice_loaded(addr))
					issue(mk(KIND_LOOKUP, addr, $urandom(),
						12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096))),
						0, '{0, 0, 0, 0});
			end else if (sel == 8) begin
				// Region added with no events loaded for it
				issue(mk(KIND_ADD, $urandom(), $urandom_range(0, 255),
					12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096))),
					0, '{0, 0, 0, 0});
			end else begin
				issue(mk(KIND_LOAD, $urandom(), $urandom(),
					12'($urandom_range(0, 4095)), 13'($urandom_range(0, 4096))),
					0, '{0, 0, 0, 0});
			end
		end

		// Wind down and let any late transaction show up
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
